>>> rtl/cave_automaton_smoothing_pass_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cave smoothing pass
// Shared concurrent-assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CAVE_AUTOMATON_SMOOTHING_PASS_ASSERT_SVH
`define CAVE_AUTOMATON_SMOOTHING_PASS_ASSERT_SVH

// same-cycle implication
`define CAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cave smoothing: assertion failed");

// next-cycle implication
`define CAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cave smoothing: assertion failed");

`endif

>>> rtl/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Types and constants shared by the cave smoothing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int TILE_W = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
	localparam logic [FH_W-1:0] FH_RESET = 13'd1024;

	localparam logic [TILE_W-1:0] WALL_CHAR   = 8'd35;
	localparam logic [TILE_W-1:0] GROUND_CHAR = 8'd32;
	localparam int WALL_LIMIT = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [TILE_W-1:0] new_tile;
		logic              frame_end;
	} result_t;

	// up to two results per tile, first slot always filled first
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

>>> rtl/cave_automaton_smoothing_pass.sv
// ----------------------------------------------------------------------------
// cave_automaton_smoothing_pass
// One generation of the cave cellular automaton over a raster tile stream.
// ----------------------------------------------------------------------------
// Throughput: one tile per cycle while the queue has space; last-row and
//   last-column tiles (two results each) outrun the one-per-cycle output.
// Order: a border result is queued while its tile is in the stage register;
//   an interior result while the tile diagonally below-right is there.
// Reset: counters, window and queue clear, size registers go to 1024 x 1024;
//   line stores are not cleared.
`timescale 1ns / 1ps

module cave_automaton_smoothing_pass (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [cas_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cas_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cas_pkg::TILE_W-1:0]        tile,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cas_pkg::ROW_W-1:0]         row,
	output logic [cas_pkg::COL_W-1:0]         column,
	output logic [cas_pkg::TILE_W-1:0]        new_tile,
	output logic                              frame_end
);

	logic [cas_pkg::FW_W-1:0]  frame_width_q;
	logic [cas_pkg::FH_W-1:0]  frame_height_q;
	logic [cas_pkg::COL_W-1:0] col_last;
	logic [cas_pkg::ROW_W-1:0] row_last;
	logic                      space;
	cas_pkg::push_t            push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= cas_pkg::FW_RESET;
			frame_height_q <= cas_pkg::FH_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				cas_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[cas_pkg::FW_W-1:0];
				end
				cas_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[cas_pkg::FH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp to 3..max, then last index
	assign col_last = (frame_width_q < cas_pkg::FW_W'(3)) ? cas_pkg::COL_W'(2)
		: (frame_width_q > cas_pkg::FW_W'(cas_pkg::MAX_WIDTH))
			? cas_pkg::COL_W'(cas_pkg::MAX_WIDTH - 1)
			: cas_pkg::COL_W'(frame_width_q - cas_pkg::FW_W'(1));
	assign row_last = (frame_height_q < cas_pkg::FH_W'(3)) ? cas_pkg::ROW_W'(2)
		: (frame_height_q > cas_pkg::FH_W'(cas_pkg::MAX_HEIGHT))
			? cas_pkg::ROW_W'(cas_pkg::MAX_HEIGHT - 1)
			: cas_pkg::ROW_W'(frame_height_q - cas_pkg::FH_W'(1));

	cas_stage u_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tile     (tile),
		.col_last (col_last),
		.row_last (row_last),
		.space    (space),
		.push     (push)
	);

	cas_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.row       (row),
		.column    (column),
		.new_tile  (new_tile),
		.frame_end (frame_end)
	);

endmodule

>>> rtl/cas_ram.sv
// ----------------------------------------------------------------------------
// cas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/cas_stage.sv
// ----------------------------------------------------------------------------
// cas_stage
// Raster counters, line stores, 3x3 window and rule evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cas_pkg::TILE_W-1:0]    tile,
	input  logic [cas_pkg::COL_W-1:0]     col_last,
	input  logic [cas_pkg::ROW_W-1:0]     row_last,
	input  logic                          space,
	output cas_pkg::push_t                push
);

	logic                       accept;
	logic                       adv;
	logic [cas_pkg::ROW_W-1:0]  row_q;
	logic [cas_pkg::COL_W-1:0]  col_q;
	logic [cas_pkg::ROW_W-1:0]  r_cur;
	logic [cas_pkg::COL_W-1:0]  c_cur;
	logic                       lc_cur;
	logic                       lr_cur;
	logic                       valid_s1;
	logic [cas_pkg::TILE_W-1:0] tile_s1;
	logic [cas_pkg::ROW_W-1:0]  r_s1;
	logic [cas_pkg::COL_W-1:0]  c_s1;
	logic                       lc_s1;
	logic                       lr_s1;
	logic                       up_rd;
	logic                       mid_rd;
	logic                       cur;
	logic [8:0]                 window_q;
	logic [8:0]                 win_new;
	logic [3:0]                 nb;
	logic                       interior;
	logic                       border;
	cas_pkg::result_t           int_res;
	cas_pkg::result_t           bord_res;

	assign adv      = valid_s1 && space;
	assign in_stall = valid_s1 && !space;
	assign accept   = in_valid && !in_stall;

	// counters beyond a shrunk frame are taken as the last row / column
	assign r_cur  = (row_q > row_last) ? row_last : row_q;
	assign c_cur  = (col_q > col_last) ? col_last : col_q;
	assign lc_cur = (c_cur == col_last);
	assign lr_cur = (r_cur == row_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			window_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (lc_cur) begin
					col_q <= '0;
					row_q <= lr_cur ? '0 : r_cur + cas_pkg::ROW_W'(1);
				end else begin
					col_q <= c_cur + cas_pkg::COL_W'(1);
					row_q <= r_cur;
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				window_q <= win_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tile_s1 <= tile;
			r_s1    <= r_cur;
			c_s1    <= c_cur;
			lc_s1   <= lc_cur;
			lr_s1   <= lr_cur;
		end
	end

	// wall flags of the two rows above
	cas_ram #(.WIDTH(1), .DEPTH(cas_pkg::MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (adv),
		.waddr (c_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (c_cur),
		.rdata (up_rd)
	);

	cas_ram #(.WIDTH(1), .DEPTH(cas_pkg::MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (adv),
		.waddr (c_s1),
		.wdata (cur),
		.re    (accept),
		.raddr (c_cur),
		.rdata (mid_rd)
	);

	assign cur     = (tile_s1 == cas_pkg::WALL_CHAR);
	assign win_new = {window_q[5:0], cur, mid_rd, up_rd};
	assign nb      = 4'($countones({win_new[8:5], win_new[3:0]}));

	assign interior = (r_s1 >= cas_pkg::ROW_W'(2)) && (c_s1 >= cas_pkg::COL_W'(2));
	assign border   = (r_s1 == '0) || lr_s1 || (c_s1 == '0) || lc_s1;

	always_comb begin
		int_res.row       = r_s1 - cas_pkg::ROW_W'(1);
		int_res.column    = c_s1 - cas_pkg::COL_W'(1);
		int_res.new_tile  = (nb > 4'(cas_pkg::WALL_LIMIT)) ? cas_pkg::WALL_CHAR
			: cas_pkg::GROUND_CHAR;
		int_res.frame_end = 1'b0;

		bord_res.row       = r_s1;
		bord_res.column    = c_s1;
		bord_res.new_tile  = tile_s1;
		bord_res.frame_end = lr_s1 && lc_s1;

		push.v0 = adv && (interior || border);
		push.v1 = adv && interior && border;
		push.r0 = interior ? int_res : bord_res;
		push.r1 = bord_res;
	end

endmodule

>>> rtl/cas_outq.sv
// ----------------------------------------------------------------------------
// cas_outq
// Small result queue: up to two results in a cycle, one out unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cave_automaton_smoothing_pass_assert.svh"

module cas_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cas_pkg::push_t               push,
	output logic                         space,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [cas_pkg::ROW_W-1:0]    row,
	output logic [cas_pkg::COL_W-1:0]    column,
	output logic [cas_pkg::TILE_W-1:0]   new_tile,
	output logic                         frame_end
);

	cas_pkg::result_t            entry_q [cas_pkg::QUEUE_DEPTH];
	logic [cas_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [cas_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [cas_pkg::QCNT_W-1:0]  cnt_q;
	logic [cas_pkg::QCNT_W-1:0]  n_push;
	logic                        pop;

	assign space     = (cnt_q <= cas_pkg::QCNT_W'(cas_pkg::QUEUE_DEPTH - 2));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign n_push    = cas_pkg::QCNT_W'(push.v0) + cas_pkg::QCNT_W'(push.v1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cas_pkg::QPTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cas_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - cas_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			entry_q[wr_ptr_q + cas_pkg::QPTR_W'(1)] <= push.r1;
		end
	end

	assign row       = entry_q[rd_ptr_q].row;
	assign column    = entry_q[rd_ptr_q].column;
	assign new_tile  = entry_q[rd_ptr_q].new_tile;
	assign frame_end = entry_q[rd_ptr_q].frame_end;

	`CAS_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= cas_pkg::QCNT_W'(cas_pkg::QUEUE_DEPTH))
	`CAS_ASSERT_NOW(a_push_room, clk, arst_n, push.v0, space)
	`CAS_ASSERT_NOW(a_pair_order, clk, arst_n, push.v1, push.v0)
	`CAS_ASSERT_NEXT(a_drain, clk, arst_n, pop && !push.v0, cnt_q == $past(cnt_q) - cas_pkg::QCNT_W'(1))

endmodule
